// ===== design/crfp_pkg.sv =====
// Shared types and constants for the camera response frame parser.
`timescale 1ns / 1ps
`default_nettype none

package crfp_pkg;

  localparam int unsigned PosW = 17;

  localparam logic [7:0] SOF_BYTE = 8'h55;
  localparam logic [7:0] EOF_BYTE = 8'h23;
  localparam logic [7:0] CMD_H    = 8'h48;
  localparam logic [7:0] CMD_R    = 8'h52;
  localparam logic [7:0] CMD_E    = 8'h45;

  // Frame positions with fixed meaning
  localparam logic [PosW-1:0] POS_HUNT    = 17'd0;
  localparam logic [PosW-1:0] POS_CMD     = 17'd1;
  localparam logic [PosW-1:0] POS_SIZE0   = 17'd2;
  localparam logic [PosW-1:0] POS_SIZE3   = 17'd5;
  localparam logic [PosW-1:0] POS_PAY1    = 17'd7;
  localparam logic [PosW-1:0] POS_R_END   = 17'd8;
  localparam logic [PosW-1:0] PAY_OFFSET  = 17'd6;
  // Last reachable position: checksum high byte of a maximum length frame
  localparam logic [PosW-1:0] POS_MAX     = 17'd65542;
  localparam logic [15:0]     LEN_MIN     = 16'd3;

  typedef enum logic [2:0] {
    EV_DISCARD = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_CSUM_LO = 3'd3,
    EV_SHORT   = 3'd4,
    EV_GOOD    = 3'd5,
    EV_BAD     = 3'd6
  } crfp_event_e;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [7:0]      command;
    logic [31:0]     size;
    logic [15:0]     running_sum;
    logic [7:0]      checksum_low;
    logic [15:0]     first_two;
    logic            done;
  } crfp_state_t;

  typedef struct packed {
    crfp_event_e event_res;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
  } crfp_result_t;

endpackage

`default_nettype wire

// ===== design/crfp_step.sv =====
// Per-byte deframing step: next parser state and the result for one byte.
`timescale 1ns / 1ps
`default_nettype none

module crfp_step (
  input  crfp_pkg::crfp_state_t  cur_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   host_sent_i,
  output crfp_pkg::crfp_state_t  nxt_o,
  output crfp_pkg::crfp_result_t res_o
);
  import crfp_pkg::*;

  logic [15:0]     len;
  logic [PosW-1:0] len_p6;
  logic [PosW-1:0] pidx;
  logic            short_cmd;

  assign len       = cur_i.size[31:16];
  assign len_p6    = {1'b0, len} + PAY_OFFSET;
  assign pidx      = cur_i.position - PAY_OFFSET;
  assign short_cmd = (cur_i.command == CMD_H) || (cur_i.command == CMD_E);

  always_comb begin
    nxt_o = cur_i;
    res_o.event_res     = EV_DISCARD;
    res_o.payload_byte  = 8'h00;
    res_o.payload_index = 16'h0000;

    if (host_sent_i) begin
      nxt_o.done     = 1'b0;
      nxt_o.position = POS_HUNT;
    end else if (cur_i.position == POS_HUNT) begin
      nxt_o.done = 1'b0;
      if (rx_byte_i == SOF_BYTE) begin
        nxt_o.running_sum = 16'h0000;
        nxt_o.position    = POS_CMD;
        res_o.event_res   = EV_HEADER;
      end
    end else if (cur_i.position == POS_CMD) begin
      nxt_o.command   = rx_byte_i;
      nxt_o.position  = POS_SIZE0;
      res_o.event_res = EV_HEADER;
    end else if (cur_i.position == POS_SIZE0) begin
      if (short_cmd && rx_byte_i == EOF_BYTE) begin
        nxt_o.done      = 1'b1;
        nxt_o.position  = POS_HUNT;
        res_o.event_res = EV_SHORT;
      end else begin
        nxt_o.size      = {24'h000000, rx_byte_i};
        nxt_o.position  = cur_i.position + 17'd1;
        res_o.event_res = EV_HEADER;
      end
    end else if (cur_i.position <= POS_SIZE3) begin
      // Size word bytes 1..3, little endian
      case (cur_i.position[1:0])
        2'd3:    nxt_o.size[15:8]  = rx_byte_i;
        2'd0:    nxt_o.size[23:16] = rx_byte_i;
        2'd1:    nxt_o.size[31:24] = rx_byte_i;
        default: nxt_o.size        = cur_i.size;
      endcase
      nxt_o.position  = cur_i.position + 17'd1;
      res_o.event_res = EV_HEADER;
    end else if (cur_i.position == POS_R_END && cur_i.command == CMD_R
                 && rx_byte_i == EOF_BYTE) begin
      nxt_o.done      = 1'b1;
      nxt_o.position  = POS_HUNT;
      res_o.event_res = EV_SHORT;
    end else if (cur_i.position == POS_R_END && len < LEN_MIN) begin
      nxt_o.done      = 1'b0;
      nxt_o.position  = POS_HUNT;
      res_o.event_res = EV_BAD;
    end else if (cur_i.position <= POS_PAY1 || cur_i.position < len_p6) begin
      // The first two payload bytes always stream, even past len
      res_o.event_res     = EV_PAYLOAD;
      res_o.payload_byte  = rx_byte_i;
      res_o.payload_index = pidx[15:0];
      if (pidx < {1'b0, len}) begin
        nxt_o.running_sum = cur_i.running_sum + {8'h00, rx_byte_i};
      end
      if (pidx == 17'd0) begin
        nxt_o.first_two[7:0] = rx_byte_i;
      end else if (pidx == 17'd1) begin
        nxt_o.first_two[15:8] = rx_byte_i;
      end
      nxt_o.position = cur_i.position + 17'd1;
    end else if (cur_i.position == len_p6) begin
      nxt_o.checksum_low = rx_byte_i;
      nxt_o.position     = cur_i.position + 17'd1;
      res_o.event_res    = EV_CSUM_LO;
    end else begin
      if ({rx_byte_i, cur_i.checksum_low} == cur_i.running_sum) begin
        nxt_o.done      = 1'b1;
        res_o.event_res = EV_GOOD;
      end else begin
        nxt_o.done      = 1'b0;
        res_o.event_res = EV_BAD;
      end
      nxt_o.position = POS_HUNT;
    end
  end

endmodule

`default_nettype wire

// ===== design/camera_response_frame_parser.sv =====
// Top level: input register, per-byte step logic, parser state and result register.
// Datapath: a byte taken into the input register goes through the step logic into the result and state registers.
// Throughput: one byte per cycle while the output is not stalled; the step logic is combinational.
// Stalls: in_stall_o rises only when the input register is full and the result is held.
// Reset: asynchronous, active low; the parser hunts for a start byte with all state zero.
`timescale 1ns / 1ps
`default_nettype none

module camera_response_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        host_sent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  command_code_o,
  output logic [31:0] size_word_o,
  output logic [15:0] packet_count_o,
  output logic        frame_done_o
);
  import crfp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   rx_byte_q;
  logic         host_sent_q;
  logic         out_valid_q;
  logic         out_adv;
  logic         in_adv;
  crfp_state_t  state_q, state_d;
  crfp_result_t res_q, res_d;

  // Result register frees up when empty or taken this cycle
  assign out_adv    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_adv) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      rx_byte_q   <= rx_byte_i;
      host_sent_q <= host_sent_i;
    end
  end

  crfp_step u_step (
    .cur_i       (state_q),
    .rx_byte_i   (rx_byte_q),
    .host_sent_i (host_sent_q),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // State only moves together with the result register, so it always
  // matches the transaction currently on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_adv) begin
        state_q <= state_d;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = res_q.event_res;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_index_o = res_q.payload_index;
  assign command_code_o  = state_q.command;
  assign size_word_o     = state_q.size;
  assign packet_count_o  = state_q.first_two;
  assign frame_done_o    = state_q.done;

  property p_no_bubble_stall;
    @(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (in_valid_q && out_valid_q);
  endproperty
  a_no_bubble_stall: assert property (p_no_bubble_stall)
    else $error("input stalled while the pipeline has room");

  property p_pos_range;
    @(posedge clk_i) disable iff (!rst_ni)
      state_q.position <= POS_MAX;
  endproperty
  a_pos_range: assert property (p_pos_range)
    else $error("frame position beyond the longest frame");

  property p_good_done;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (res_q.event_res == EV_GOOD || res_q.event_res == EV_SHORT))
        |-> frame_done_o;
  endproperty
  a_good_done: assert property (p_good_done)
    else $error("completed frame without done flag");

  property p_end_hunts;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (res_q.event_res == EV_GOOD || res_q.event_res == EV_BAD
                       || res_q.event_res == EV_SHORT))
        |-> (state_q.position == POS_HUNT);
  endproperty
  a_end_hunts: assert property (p_end_hunts)
    else $error("frame ended but parser did not return to hunting");

  property p_payload_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && res_q.event_res != EV_PAYLOAD)
        |-> (payload_byte_o == 8'h00 && payload_index_o == 16'h0000);
  endproperty
  a_payload_zero: assert property (p_payload_zero)
    else $error("payload fields set outside a payload transaction");

endmodule

`default_nettype wire
